/* src/wfba_pkg.sv */
// Package: constants, types and helpers shared by the worst-fit allocator files.
package wfba_pkg;

  localparam int MAX_BLOCKS = 32;
  localparam int SIZE_BITS  = 16;

  localparam int IDX_W  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
  localparam int CFG_W  = 6;
  localparam int BLK_W  = 5;
  localparam int FSIZE_W = 16;
  localparam int TDATA_W = ((BLK_W + FSIZE_W + 7) / 8) * 8;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_ALLOC = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_e;

  typedef struct packed {
    logic             start;
    logic             rvalid;
    logic [IDX_W-1:0] ridx;
  } scan_ctl_t;

  function automatic logic [CNT_W-1:0] sat_blocks(input logic [CFG_W-1:0] v);
    logic [CNT_W-1:0] r;
    if (32'(v) > 32'(MAX_BLOCKS)) r = CNT_W'(MAX_BLOCKS);
    else                          r = CNT_W'(v);
    return r;
  endfunction

endpackage

/* src/worst_fit_block_allocator.sv */
// Top level: worst-fit block allocator over a free-size table RAM.
// Load word: written to the table on acceptance, no result.
// Allocate word: scans the first n table entries, then writes one result word,
//   n = min(blocks_in_use, 32); no new word is taken until the result is written back.
// The scan reads one table entry per cycle; a stalled result holds the write-back.
// Reset clears control and blocks_in_use; table contents are undefined until loaded.
module worst_fit_block_allocator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [wfba_pkg::TDATA_W-1:0]  s_axis_tdata,  // block_index, size_value
  input  logic                          s_axis_tuser,  // func
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [wfba_pkg::TDATA_W-1:0]  m_axis_tdata,  // chosen_block, leftover
  output logic                          m_axis_tuser,  // placed
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [wfba_pkg::CFG_W-1:0]    cfg_data_i
);
  import wfba_pkg::*;

  logic [CFG_W-1:0]     blocks_in_use_q;
  logic [BLK_W-1:0]     in_index;
  logic [SIZE_BITS-1:0] in_size;
  logic                 rd_en, wb, out_free;
  logic [IDX_W-1:0]     rd_addr;
  scan_ctl_t            scan_ctl;
  logic [SIZE_BITS-1:0] rdata;
  logic                 found;
  logic [IDX_W-1:0]     best_pos;
  logic [SIZE_BITS-1:0] best_left;
  logic                 load_we;
  logic                 we;
  logic [IDX_W-1:0]     waddr;
  logic [SIZE_BITS-1:0] wdata;
  logic                 m_valid_q;
  logic                 m_placed_q;
  logic [BLK_W-1:0]     m_blk_q;
  logic [FSIZE_W-1:0]   m_left_q;

  assign in_index = s_axis_tdata[BLK_W-1:0];
  assign in_size  = SIZE_BITS'(s_axis_tdata[BLK_W+FSIZE_W-1:BLK_W]);

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blocks_in_use_q <= '0;
    end else if (cfg_valid_i) begin
      blocks_in_use_q <= cfg_data_i;
    end
  end

  assign out_free = !m_valid_q || m_axis_tready;

  wfba_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (s_axis_tvalid),
    .in_func_i       (s_axis_tuser),
    .in_ready_o      (s_axis_tready),
    .blocks_in_use_i (blocks_in_use_q),
    .out_free_i      (out_free),
    .rd_en_o         (rd_en),
    .rd_addr_o       (rd_addr),
    .scan_ctl_o      (scan_ctl),
    .wb_o            (wb)
  );

  wfba_best u_best (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .scan_ctl_i  (scan_ctl),
    .req_i       (in_size),
    .rdata_i     (rdata),
    .found_o     (found),
    .best_pos_o  (best_pos),
    .best_left_o (best_left)
  );

  assign load_we = s_axis_tvalid && s_axis_tready && (s_axis_tuser == FUNC_LOAD) &&
                   (32'(in_index) < 32'(MAX_BLOCKS));
  assign we      = load_we || (wb && found);
  assign waddr   = load_we ? IDX_W'(in_index) : best_pos;
  assign wdata   = load_we ? in_size : best_left;

  wfba_ram #(
    .Width (SIZE_BITS),
    .Depth (MAX_BLOCKS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (wb) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wb) begin
      m_placed_q <= found;
      m_blk_q    <= found ? BLK_W'(best_pos) : '0;
      m_left_q   <= found ? FSIZE_W'(best_left) : '0;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_placed_q;
  assign m_axis_tdata  = TDATA_W'({m_left_q, m_blk_q});

endmodule

/* src/wfba_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module wfba_ram #(
  parameter int Width = 16,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/wfba_ctrl.sv */
// Sequencer: accepts words, walks the table read addresses and hands off the write-back.
module wfba_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_func_i,
  output logic                        in_ready_o,
  input  logic [wfba_pkg::CFG_W-1:0]  blocks_in_use_i,
  input  logic                        out_free_i,
  output logic                        rd_en_o,
  output logic [wfba_pkg::IDX_W-1:0]  rd_addr_o,
  output wfba_pkg::scan_ctl_t         scan_ctl_o,
  output logic                        wb_o
);
  import wfba_pkg::*;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] n_q, n_d;
  logic             rvalid_q;
  logic [IDX_W-1:0] ridx_q;
  logic             accept_alloc;

  assign in_ready_o   = (state_q == S_IDLE);
  assign accept_alloc = in_valid_i && in_ready_o && (in_func_i == FUNC_ALLOC);
  assign rd_en_o      = (state_q == S_SCAN) && (cnt_q < n_q);
  assign rd_addr_o    = cnt_q[IDX_W-1:0];
  assign wb_o         = (state_q == S_DONE) && out_free_i;

  assign scan_ctl_o.start  = accept_alloc;
  assign scan_ctl_o.rvalid = rvalid_q;
  assign scan_ctl_o.ridx   = ridx_q;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    n_d     = n_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept_alloc) begin
          n_d     = sat_blocks(blocks_in_use_i);
          cnt_d   = '0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (rd_en_o) begin
          cnt_d = cnt_q + CNT_W'(1);
        end else if (!rvalid_q) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      n_q      <= '0;
      rvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      n_q      <= n_d;
      rvalid_q <= rd_en_o;
    end
  end

  always_ff @(posedge clk_i) begin
    ridx_q <= rd_addr_o;
  end

endmodule

/* src/wfba_best.sv */
// Best-candidate tracker: keeps the largest leftover seen during a scan.
module wfba_best (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  wfba_pkg::scan_ctl_t           scan_ctl_i,
  input  logic [wfba_pkg::SIZE_BITS-1:0] req_i,
  input  logic [wfba_pkg::SIZE_BITS-1:0] rdata_i,
  output logic                          found_o,
  output logic [wfba_pkg::IDX_W-1:0]    best_pos_o,
  output logic [wfba_pkg::SIZE_BITS-1:0] best_left_o
);
  import wfba_pkg::*;

  logic                 found_q;
  logic [IDX_W-1:0]     best_pos_q;
  logic [SIZE_BITS-1:0] best_left_q;
  logic [SIZE_BITS-1:0] req_q;
  logic [SIZE_BITS-1:0] left;
  logic                 take;

  assign left = rdata_i - req_q;
  assign take = scan_ctl_i.rvalid && (rdata_i >= req_q) &&
                (!found_q || (left > best_left_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (scan_ctl_i.start) begin
      found_q <= 1'b0;
    end else if (take) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (scan_ctl_i.start) begin
      req_q <= req_i;
    end
    if (take) begin
      best_pos_q  <= scan_ctl_i.ridx;
      best_left_q <= left;
    end
  end

  assign found_o     = found_q;
  assign best_pos_o  = best_pos_q;
  assign best_left_o = best_left_q;

endmodule

/* src/wfba_checker.sv */
// Port-level checker for the worst-fit allocator, bound to the top level.
module wfba_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic                         s_axis_tuser,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [wfba_pkg::TDATA_W-1:0] m_axis_tdata,
  input logic                         m_axis_tuser
);
  import wfba_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result word dropped while stalled");

  a_not_placed_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> (m_axis_tdata == '0))
    else $error("unplaced result carries nonzero fields");

  a_alloc_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == FUNC_ALLOC) |=> !s_axis_tready)
    else $error("input accepted during a scan");

  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == FUNC_LOAD) && !m_axis_tvalid
    |=> !m_axis_tvalid)
    else $error("load produced a result");

endmodule

bind worst_fit_block_allocator wfba_checker u_wfba_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
